>>> rtl/hvt_pkg.sv
package hvt_pkg;

   localparam int unsigned DIM = 4;
   localparam int unsigned DW = 32;
   localparam int unsigned SW = 50;
   localparam int unsigned QW = 34;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_XFORM = 1'b1;

   localparam logic signed [DW-1:0] ONE_Q16 = 32'sh0001_0000;
   localparam logic [DW-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [DW-1:0] SAT_NEG = 32'h8000_0000;

   typedef logic signed [DW-1:0] word_type;
   typedef logic signed [SW-1:0] sum_type;

   typedef struct packed {
      logic valid;
      logic zero_w;
   } ctl_type;

endpackage

>>> rtl/hvt_lane.sv
module hvt_lane (
   input  logic clock,
   input  logic enable,
   input  hvt_pkg::word_type m0,
   input  hvt_pkg::word_type m1,
   input  hvt_pkg::word_type m2,
   input  hvt_pkg::word_type m3,
   input  hvt_pkg::word_type v0,
   input  hvt_pkg::word_type v1,
   input  hvt_pkg::word_type v2,
   input  hvt_pkg::word_type v3,
   output hvt_pkg::sum_type  sum
);

   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [63:0] p0_in, p1_in, p2_in, p3_in;
   hvt_pkg::sum_type sum_ff, sum_in;

   always_comb begin
      p0_in = 64'(m0) * 64'(v0);
      p1_in = 64'(m1) * 64'(v1);
      p2_in = 64'(m2) * 64'(v2);
      p3_in = 64'(m3) * 64'(v3);
      sum_in = hvt_pkg::SW'(p0_ff >>> 16) + hvt_pkg::SW'(p1_ff >>> 16)
             + hvt_pkg::SW'(p2_ff >>> 16) + hvt_pkg::SW'(p3_ff >>> 16);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

>>> rtl/hvt_div.sv
module hvt_div (
   input  logic clock,
   input  logic enable,
   input  hvt_pkg::sum_type num,
   input  hvt_pkg::sum_type den,
   output hvt_pkg::word_type quo
);

   localparam int unsigned NW = hvt_pkg::SW + 16;
   localparam int unsigned ST = hvt_pkg::QW;

   logic [NW-1:0] rem_ff [ST+1];
   logic [NW-1:0] dvs_ff [ST+1];
   logic [ST-1:0] q_ff   [ST+1];
   logic          neg_ff [ST+1];
   logic [hvt_pkg::SW-1:0] un, ud;
   logic [ST-1:0] mag;
   hvt_pkg::word_type quo_ff, quo_in;

   always_comb begin
      un = num[hvt_pkg::SW-1] ? hvt_pkg::SW'(-num) : num;
      ud = den[hvt_pkg::SW-1] ? hvt_pkg::SW'(-den) : den;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= {un, 16'b0};
         dvs_ff[0] <= NW'(ud);
         q_ff[0] <= '0;
         neg_ff[0] <= num[hvt_pkg::SW-1] ^ den[hvt_pkg::SW-1];
         for (int i = 0; i < ST; i++) begin
            if ((rem_ff[i] >> (ST - 1 - i)) >= dvs_ff[i]) begin
               rem_ff[i+1] <= rem_ff[i] - (dvs_ff[i] << (ST - 1 - i));
               q_ff[i+1] <= q_ff[i] | (ST'(1) << (ST - 1 - i));
            end else begin
               rem_ff[i+1] <= rem_ff[i];
               q_ff[i+1] <= q_ff[i];
            end
            dvs_ff[i+1] <= dvs_ff[i];
            neg_ff[i+1] <= neg_ff[i];
         end
         quo_ff <= quo_in;
      end
   end

   always_comb begin
      mag = q_ff[ST];
      if (neg_ff[ST]) begin
         if (mag > ST'(hvt_pkg::SAT_NEG)) quo_in = hvt_pkg::SAT_NEG;
         else quo_in = hvt_pkg::DW'(-mag);
      end else begin
         if (mag > ST'(hvt_pkg::SAT_POS)) quo_in = hvt_pkg::SAT_POS;
         else quo_in = hvt_pkg::DW'(mag);
      end
   end

   assign quo = quo_ff;

endmodule

>>> rtl/homogeneous_vertex_transform.sv
// Homogeneous 4x4 vertex transform in signed Q16.16.
// Request channel: req_valid/req_stall with command, row_index, col_index,
// entry_value and vec_x..vec_w. A load request writes one matrix entry and
// gives no response. A transform request multiplies the row vector by the
// matrix in four parallel lanes, one per output component, and divides x, y
// and z by w in three pipelined dividers (one quotient bit per stage).
// Response channel: rsp_valid/rsp_stall with out_x, out_y, out_z, zero_w.
// The pipeline has two multiply/add stages, one divider operand stage, 34
// divide stages, a saturation stage and the output register. Throughput is
// one request per cycle while no waiting response is stalled. A load takes
// effect for the next request in the following cycle.
// When the receiver stalls a waiting response in the output register, the
// whole pipeline holds and req_stall is raised, so nothing is lost.
// Reset returns the matrix to the identity and empties the pipeline.
// A zero w sum from the w lane gives zero outputs with zero_w set.
module homogeneous_vertex_transform (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_command,
   input  logic [1:0] req_row_index,
   input  logic [1:0] req_col_index,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic signed [31:0] req_vec_w,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic rsp_zero_w
);

   localparam int unsigned LAT = hvt_pkg::QW + 4;

   hvt_pkg::word_type mat_ff [16];
   hvt_pkg::sum_type  t [4];
   hvt_pkg::word_type q [3];
   hvt_pkg::ctl_type  ctl_ff [LAT];
   logic zw_ff, zw_in;
   logic enable, accept;
   logic out_valid_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic oz_flag_ff;

   assign enable = !out_valid_ff || !rsp_stall;
   assign req_stall = !enable;
   assign accept = req_valid && enable;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++)
            mat_ff[i] <= (i % 5 == 0) ? hvt_pkg::ONE_Q16 : '0;
      end else if (accept && req_command == hvt_pkg::CMD_LOAD) begin
         mat_ff[{req_row_index, req_col_index}] <= req_entry_value;
      end
   end

   for (genvar j = 0; j < 4; j++) begin : g_lane
      hvt_lane u_lane (
         .clock(clock), .enable(enable),
         .m0(mat_ff[j]), .m1(mat_ff[4+j]), .m2(mat_ff[8+j]), .m3(mat_ff[12+j]),
         .v0(req_vec_x), .v1(req_vec_y), .v2(req_vec_z), .v3(req_vec_w),
         .sum(t[j])
      );
   end

   for (genvar j = 0; j < 3; j++) begin : g_div
      hvt_div u_div (
         .clock(clock), .enable(enable), .num(t[j]), .den(t[3]), .quo(q[j])
      );
   end

   assign zw_in = (t[3] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) ctl_ff[i] <= '0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         ctl_ff[0].valid <= accept && req_command == hvt_pkg::CMD_XFORM;
         ctl_ff[0].zero_w <= 1'b0;
         for (int i = 1; i < LAT; i++) begin
            ctl_ff[i].valid <= ctl_ff[i-1].valid;
            ctl_ff[i].zero_w <= (i == 2) ? zw_in : ctl_ff[i-1].zero_w;
         end
         out_valid_ff <= ctl_ff[LAT-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zw_ff <= ctl_ff[LAT-1].zero_w;
         oz_flag_ff <= ctl_ff[LAT-1].zero_w;
         ox_ff <= ctl_ff[LAT-1].zero_w ? '0 : q[0];
         oy_ff <= ctl_ff[LAT-1].zero_w ? '0 : q[1];
         oz_ff <= ctl_ff[LAT-1].zero_w ? '0 : q[2];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_out_z = oz_ff;
   assign rsp_zero_w = oz_flag_ff && zw_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x))
      else $error("response changed while stalled");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_w |-> rsp_out_x == '0 && rsp_out_y == '0)
      else $error("zero w gave nonzero output");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("stall without waiting response");
`endif

endmodule
